>>> hw/rtl/xtkd_pkg.sv
// ----------------------------------------------------------------------------
// xtkd_pkg
// shared types and constants for the xorshift table key derivation block
// ----------------------------------------------------------------------------
package xtkd_pkg;

  localparam int KEY_WORDS_DEF = 4;
  localparam int GEN_WORDS     = 4;
  localparam int TBL_DEPTH     = 64;
  localparam int TBL_AW        = 6;
  localparam int WORD_W        = 32;

  typedef enum logic [1:0] {
    OP_WRITE_TABLE = 2'd0,
    OP_WRITE_GEN   = 2'd1,
    OP_GENERATE    = 2'd2,
    OP_UNUSED      = 2'd3
  } opcode_t;

  // controller to datapath commands
  typedef struct packed {
    logic       tbl_wr;
    logic       gen_wr;
    logic       step;
    logic       rd;
    logic       merge;
    logic       load_out;
    logic [1:0] word_index;
    logic       last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

>>> hw/rtl/xtkd_datapath.sv
// ----------------------------------------------------------------------------
// xtkd_datapath
// generator words, table memory, byte assembly and output register
// ----------------------------------------------------------------------------
module xtkd_datapath
  import xtkd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [TBL_AW-1:0]   slot,
  input  logic [WORD_W-1:0]   value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_word_index,
  output logic [WORD_W-1:0]   out_key_word,
  output logic                out_last
);

  logic [WORD_W-1:0] gen_r   [GEN_WORDS];
  logic [WORD_W-1:0] gen_nxt [GEN_WORDS];
  logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] acc_nxt;
  logic [WORD_W-1:0] t0;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t_out;
  logic [7:0]        sel_byte;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic [1:0]        out_idx_r;
  logic              out_last_r;

  // xorshift128 step
  always_comb begin
    t0    = gen_r[0] ^ (gen_r[0] << 11);
    t1    = t0 ^ (t0 >> 8);
    t_out = t1 ^ gen_r[3] ^ (gen_r[3] >> 19);
  end

  always_comb begin
    for (int i = 0; i < GEN_WORDS; i++) begin
      gen_nxt[i] = gen_r[i];
    end
    if (cmd.step) begin
      gen_nxt[0] = gen_r[1];
      gen_nxt[1] = gen_r[2];
      gen_nxt[2] = gen_r[3];
      gen_nxt[3] = t_out;
    end else if (cmd.gen_wr && (slot[TBL_AW-1:2] == '0)) begin
      gen_nxt[slot[1:0]] = value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GEN_WORDS; i++) begin
        gen_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < GEN_WORDS; i++) begin
        gen_r[i] <= gen_nxt[i];
      end
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[slot] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= tbl_mem[t_out[WORD_W-1 -: TBL_AW]];
    end
  end

  // byte select from top two bits of second output
  always_comb begin
    case (t_out[WORD_W-1 -: 2])
      2'd0:    sel_byte = rdata_r[7:0];
      2'd1:    sel_byte = rdata_r[15:8];
      2'd2:    sel_byte = rdata_r[23:16];
      default: sel_byte = rdata_r[31:24];
    endcase
  end

  assign acc_nxt = {acc_r[WORD_W-9:0], sel_byte};

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      acc_r <= acc_nxt;
    end
  end

  // output register
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r <= acc_nxt;
      out_idx_r  <= cmd.word_index;
      out_last_r <= cmd.last;
    end
  end

  assign status.out_busy = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_word_index  = out_idx_r;
  assign out_key_word    = out_word_r;
  assign out_last        = out_last_r;

endmodule

>>> hw/rtl/xtkd_ctrl.sv
// ----------------------------------------------------------------------------
// xtkd_ctrl
// sequencer for table and generator writes and key generation
// ----------------------------------------------------------------------------
module xtkd_ctrl
  import xtkd_pkg::*;
#(
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  opcode_t opcode,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int WCW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam logic [WCW-1:0] LAST_WORD = WCW'(KEY_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_SEL  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     byte_cnt_r, byte_cnt_nxt;
  logic [WCW-1:0] word_cnt_r, word_cnt_nxt;
  logic [WCW+1:0] word_ext;

  assign word_ext = {2'b00, word_cnt_r};

  always_comb begin
    state_nxt      = state_r;
    byte_cnt_nxt   = byte_cnt_r;
    word_cnt_nxt   = word_cnt_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.word_index = word_ext[1:0];
    cmd.last       = (word_cnt_r == LAST_WORD);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_WRITE_TABLE: cmd.tbl_wr = 1'b1;
            OP_WRITE_GEN:   cmd.gen_wr = 1'b1;
            OP_GENERATE: begin
              state_nxt    = ST_ADDR;
              byte_cnt_nxt = '0;
              word_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADDR: begin
        cmd.step  = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (!((byte_cnt_r == 2'd3) && status.out_busy)) begin
          cmd.step     = 1'b1;
          cmd.merge    = 1'b1;
          byte_cnt_nxt = byte_cnt_r + 2'd1;
          state_nxt    = ST_ADDR;
          if (byte_cnt_r == 2'd3) begin
            cmd.load_out = 1'b1;
            if (word_cnt_r == LAST_WORD) begin
              state_nxt = ST_IDLE;
            end else begin
              word_cnt_nxt = word_cnt_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_cnt_r <= '0;
      word_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      word_cnt_r <= word_cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/xorshift_table_key_derive_top.sv
// ----------------------------------------------------------------------------
// xorshift_table_key_derive_top
// key derivation from a xorshift128 generator and a 64-word byte table
// ----------------------------------------------------------------------------
//  channel  dir  tdata / tuser / tlast
//  in_      in   tdata {value[37:6], slot[5:0]}, tuser opcode[1:0]
//  out_     out  tdata {key_word[33:2], word_index[1:0]}, tlast last
//
//  table and generator writes are accepted in idle
//  generate: after the accept cycle, states ST_ADDR and ST_SEL, two generator steps per
//  byte with the table memory read registered between them
//  reset clears generator words and control; the table is not cleared
//  the last byte of a word waits while the output register holds a result
//  that is not yet taken; a new transaction is taken once the key is done
module xorshift_table_key_derive_top
  import xtkd_pkg::*;
#(
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot, value, zero pad
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // word_index, key_word, zero pad
  output logic        out_tlast
);

  cmd_t        cmd;
  status_t     status;
  opcode_t     opcode;
  logic [1:0]  out_word_index;
  logic [31:0] out_key_word;

  assign opcode = opcode_t'(in_tuser);

  xtkd_ctrl #(
    .KEY_WORDS(KEY_WORDS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .opcode  (opcode),
    .status  (status),
    .cmd     (cmd)
  );

  xtkd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .slot          (in_tdata[5:0]),
    .value         (in_tdata[37:6]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_word_index(out_word_index),
    .out_key_word  (out_key_word),
    .out_last      (out_tlast)
  );

  assign out_tdata = {6'b0, out_key_word, out_word_index};

  // a generate transaction makes the block busy
  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_GENERATE) |=> !in_tready)
    else $error("ready after generate transaction");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_tvalid && !out_tready))
    else $error("output register overwritten");

  // writes only while idle, never together with a generator step
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tbl_wr || cmd.gen_wr) |-> (in_tready && !cmd.step))
    else $error("write outside idle");

  // the table read is always followed by the select state, which neither reads nor raises ready
  a_rd_merge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !in_tready && !cmd.rd)
    else $error("table read not followed by select");

endmodule
